>>> rtl/stef_pkg.sv
// ----------------------------------------------------------------------------
// stef_pkg
// Shared widths, types and the square-root step for the edge check pipeline.
// ----------------------------------------------------------------------------
package stef_pkg;

	localparam int SPACE_DIMS = 3;   // spatial coordinates in use, 1 to 3

	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;   // difference of two coordinates
	localparam int SQR_W   = 2 * DIFF_W;    // square of a difference magnitude
	localparam int GAP_W   = 32;            // accepted gap is below 2^32
	localparam int DIST_W  = 33;            // floor distance stays below 2^33
	localparam int RAD_W   = 68;            // square-root radicand
	localparam int ROOT_W  = RAD_W / 2;     // one root bit per step
	localparam int REM_W   = ROOT_W + 3;    // partial remainder

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	// one restoring square-root step: brings down two radicand bits, one root bit
	function automatic sqrt_t sqrt_step(input sqrt_t a);
		sqrt_t            r;
		logic [REM_W-1:0] rem2;
		logic [REM_W-1:0] trial;
		rem2  = {a.rem[REM_W-3:0], a.rad[RAD_W-1:RAD_W-2]};
		trial = {1'b0, a.root, 2'b01};
		r.rad = {a.rad[RAD_W-3:0], 2'b00};
		if (rem2 >= trial) begin
			r.rem  = rem2 - trial;
			r.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = rem2;
			r.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

>>> rtl/spacetime_edge_feasibility_unit.sv
// ----------------------------------------------------------------------------
// spacetime_edge_feasibility_unit
// Space-time edge check: gap, Euclidean distance, speed limits and cost.
// ----------------------------------------------------------------------------
// Takes one edge transaction per clock while in_stall is low and returns one
// result per edge, in order. The pipeline is made up of the two bit-serial
// square-root pipelines (34 stages each, one root bit per stage) plus the
// difference, square, speed-product and summing stages. The whole pipeline
// moves as one: it holds only while a result sits in the output register and
// the consumer stalls, so in_stall simply mirrors that condition. The speed
// test is exact: distance * 2^16 is compared with bound * gap, so no divider
// is needed. An edge whose gap is not above the tolerance, or whose speed
// falls outside [min_speed - tolerance, max_speed + tolerance], returns all
// zeros. Configuration writes are always taken (cfg_ready is tied high) and
// must only be made with the pipeline empty.
// ----------------------------------------------------------------------------
module spacetime_edge_feasibility_unit
	import stef_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [31:0]   from_x,
	input  logic signed [31:0]   from_y,
	input  logic signed [31:0]   from_z,
	input  logic signed [31:0]   from_tgo,
	input  logic signed [31:0]   to_x,
	input  logic signed [31:0]   to_y,
	input  logic signed [31:0]   to_z,
	input  logic signed [31:0]   to_time,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 edge_valid,
	output logic [32:0]          edge_duration,
	output logic [35:0]          edge_distance,
	output logic [35:0]          edge_cost
);

	// configuration registers
	logic [31:0] min_speed_q;
	logic [31:0] max_speed_q;
	logic [15:0] tolerance_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q <= '0;
			max_speed_q <= 32'd65536;
			tolerance_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIN_SPEED: min_speed_q <= cfg_data;
				CFG_MAX_SPEED: max_speed_q <= cfg_data;
				CFG_TOLERANCE: tolerance_q <= cfg_data[15:0];
				default: ;   // unknown index ignored
			endcase
		end
	end

	// global advance: only a stalled result in the output register holds things
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic signed [COORD_W-1:0] from_c [3];
	logic signed [COORD_W-1:0] to_c   [3];
	assign from_c[0] = from_x;
	assign from_c[1] = from_y;
	assign from_c[2] = from_z;
	assign to_c[0]   = to_x;
	assign to_c[1]   = to_y;
	assign to_c[2]   = to_z;

	// stage 1: coordinate differences and time gap
	logic                     vld_s1;
	logic signed [DIFF_W-1:0] diff_s1 [SPACE_DIMS];
	logic signed [DIFF_W-1:0] gap_s1;

	// stage 2: magnitudes, gap test
	logic                vld_s2;
	logic                ok_s2;
	logic [DIFF_W-1:0]   mag_s2 [SPACE_DIMS];
	logic [GAP_W-1:0]    g_s2;

	// stage 3: squares
	logic                vld_s3;
	logic                ok_s3;
	logic [SQR_W-1:0]    sqr_s3 [SPACE_DIMS];
	logic [GAP_W-1:0]    g_s3;

	// distance square root, entry 0 is the summed radicand
	sqrt_t            dsq_s   [ROOT_W+1];
	logic             dvld_s  [ROOT_W+1];
	logic             dok_s   [ROOT_W+1];
	logic [GAP_W-1:0] dg_s    [ROOT_W+1];

	// stage 5: speed bound products
	logic               vld_s5;
	logic               ok_s5;
	logic               lo_en_s5;
	logic [64:0]        pu_s5;
	logic [64:0]        pl_s5;
	logic [DIST_W-1:0]  d_s5;
	logic [GAP_W-1:0]   g_s5;

	// stage 6: speed tests, cost squares
	logic               vld_s6;
	logic               ok_s6;
	logic [63:0]        gg_s6;
	logic [65:0]        dd_s6;
	logic [DIST_W-1:0]  d_s6;
	logic [GAP_W-1:0]   g_s6;

	// cost square root, entry 0 is the summed radicand
	sqrt_t             csq_s  [ROOT_W+1];
	logic              cvld_s [ROOT_W+1];
	logic              cok_s  [ROOT_W+1];
	logic [GAP_W-1:0]  cg_s   [ROOT_W+1];
	logic [DIST_W-1:0] cd_s   [ROOT_W+1];

	logic signed [DIFF_W-1:0] tol_s;
	logic [32:0]              upper;
	logic [31:0]              lower;
	logic                     lo_en;
	logic [64:0]              d_shift;
	logic [SQR_W+1:0]         dist_sum;
	logic [DIST_W-1:0]        d_root;

	assign tol_s   = $signed({{(DIFF_W-16){1'b0}}, tolerance_q});
	assign upper   = {1'b0, max_speed_q} + {17'b0, tolerance_q};
	assign lo_en   = min_speed_q > {16'b0, tolerance_q};
	assign lower   = min_speed_q - {16'b0, tolerance_q};
	assign d_root  = dsq_s[ROOT_W].root[DIST_W-1:0];
	assign d_shift = {16'b0, d_s5, 16'b0};

	always_comb begin
		dist_sum = '0;
		for (int i = 0; i < SPACE_DIMS; i++)
			dist_sum = dist_sum + {2'b00, sqr_s3[i]};
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			for (int k = 0; k <= ROOT_W; k++) begin
				dvld_s[k] <= 1'b0;
				cvld_s[k] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			dvld_s[0] <= vld_s3;
			for (int k = 1; k <= ROOT_W; k++)
				dvld_s[k] <= dvld_s[k-1];
			vld_s5    <= dvld_s[ROOT_W];
			vld_s6    <= vld_s5;
			cvld_s[0] <= vld_s6;
			for (int k = 1; k <= ROOT_W; k++)
				cvld_s[k] <= cvld_s[k-1];
			out_valid <= cvld_s[ROOT_W];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < SPACE_DIMS; i++) begin
				diff_s1[i] <= DIFF_W'(to_c[i]) - DIFF_W'(from_c[i]);
				mag_s2[i]  <= diff_s1[i][DIFF_W-1] ? DIFF_W'(-diff_s1[i])
				                                   : DIFF_W'(diff_s1[i]);
				sqr_s3[i]  <= SQR_W'(mag_s2[i]) * SQR_W'(mag_s2[i]);
			end
			gap_s1 <= DIFF_W'(from_tgo) - DIFF_W'(to_time);
			ok_s2  <= gap_s1 > tol_s;
			g_s2   <= gap_s1[GAP_W-1:0];
			ok_s3  <= ok_s2;
			g_s3   <= g_s2;

			dsq_s[0] <= '{rad: RAD_W'(dist_sum), rem: '0, root: '0};
			dok_s[0] <= ok_s3;
			dg_s[0]  <= g_s3;
			for (int k = 1; k <= ROOT_W; k++) begin
				dsq_s[k] <= sqrt_step(dsq_s[k-1]);
				dok_s[k] <= dok_s[k-1];
				dg_s[k]  <= dg_s[k-1];
			end

			pu_s5    <= 65'(upper) * 65'(dg_s[ROOT_W]);
			pl_s5    <= 65'(lower) * 65'(dg_s[ROOT_W]);
			lo_en_s5 <= lo_en;
			ok_s5    <= dok_s[ROOT_W];
			d_s5     <= d_root;
			g_s5     <= dg_s[ROOT_W];

			ok_s6 <= ok_s5 && !(d_shift > pu_s5) && !(lo_en_s5 && (d_shift < pl_s5));
			gg_s6 <= 64'(g_s5) * 64'(g_s5);
			dd_s6 <= 66'(d_s5) * 66'(d_s5);
			d_s6  <= d_s5;
			g_s6  <= g_s5;

			csq_s[0] <= '{rad: RAD_W'(gg_s6) + RAD_W'(dd_s6), rem: '0, root: '0};
			cok_s[0] <= ok_s6;
			cg_s[0]  <= g_s6;
			cd_s[0]  <= d_s6;
			for (int k = 1; k <= ROOT_W; k++) begin
				csq_s[k] <= sqrt_step(csq_s[k-1]);
				cok_s[k] <= cok_s[k-1];
				cg_s[k]  <= cg_s[k-1];
				cd_s[k]  <= cd_s[k-1];
			end

			// failed edges report all zeros
			edge_valid    <= cok_s[ROOT_W];
			edge_duration <= cok_s[ROOT_W] ? {1'b0, cg_s[ROOT_W]} : '0;
			edge_distance <= cok_s[ROOT_W] ? 36'(cd_s[ROOT_W]) : '0;
			edge_cost     <= cok_s[ROOT_W] ? 36'(csq_s[ROOT_W].root) : '0;
		end
	end

endmodule

>>> bench/edge_check_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_check_monitor
// Watches the edge, result and register channels of the edge feasibility
// unit, predicts each result and compares it with what comes out.
// ----------------------------------------------------------------------------
module edge_check_monitor
	import stef_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic signed [31:0]   from_x,
	input  logic signed [31:0]   from_y,
	input  logic signed [31:0]   from_z,
	input  logic signed [31:0]   from_tgo,
	input  logic signed [31:0]   to_x,
	input  logic signed [31:0]   to_y,
	input  logic signed [31:0]   to_z,
	input  logic signed [31:0]   to_time,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 edge_valid,
	input  logic [32:0]          edge_duration,
	input  logic [35:0]          edge_distance,
	input  logic [35:0]          edge_cost,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic        ok;
		logic [32:0] duration;
		logic [35:0] distance;
		logic [35:0] cost;
	} edge_res_t;

	edge_res_t   edge_res_q[$];
	logic [31:0] lim_min;
	logic [31:0] lim_max;
	logic [15:0] lim_tol;

	assign pending = edge_res_q.size();

	function automatic logic [63:0] root_floor(input logic [127:0] n);
		logic [63:0]  r;
		logic [63:0]  c;
		logic [127:0] cc;
		r = '0;
		for (int b = 36; b >= 0; b--) begin
			c  = r | (64'd1 << b);
			cc = {64'd0, c} * {64'd0, c};
			if (cc <= n)
				r = c;
		end
		return r;
	endfunction

	function automatic edge_res_t edge_predict(input logic signed [31:0] fp [4],
			input logic signed [31:0] tp [4]);
		edge_res_t          e;
		logic signed [63:0] gap;
		logic signed [63:0] diff;
		logic [63:0]        mag;
		logic [127:0]       sum;
		logic [63:0]        g;
		logic [63:0]        d;
		logic [63:0]        bound;
		logic [127:0]       lhs;
		e   = '0;
		gap = 64'(fp[3]) - 64'(tp[3]);
		if (gap <= $signed({48'd0, lim_tol}))
			return e;
		g   = gap;
		sum = '0;
		for (int i = 0; i < SPACE_DIMS; i++) begin
			diff = 64'(tp[i]) - 64'(fp[i]);
			mag  = diff < 0 ? -diff : diff;
			sum  = sum + {64'd0, mag} * {64'd0, mag};
		end
		d     = root_floor(sum);
		lhs   = {64'd0, d} << 16;
		bound = {32'd0, lim_max} + {48'd0, lim_tol};
		if (lhs > {64'd0, bound} * {64'd0, g})
			return e;
		if ({16'd0, lim_min} > {32'd0, lim_tol}) begin
			bound = {32'd0, lim_min} - {48'd0, lim_tol};
			if (lhs < {64'd0, bound} * {64'd0, g})
				return e;
		end
		e.ok       = 1'b1;
		e.duration = g[32:0];
		e.distance = d[35:0];
		e.cost     = 36'(root_floor({64'd0, g} * {64'd0, g} + {64'd0, d} * {64'd0, d}));
		return e;
	endfunction

	task automatic report(input string what, input logic [35:0] got, input logic [35:0] want);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] fp [4];
		logic signed [31:0] tp [4];
		edge_res_t          want;
		if (!arst_n) begin
			lim_min    <= 32'd0;
			lim_max    <= 32'd65536;
			lim_tol    <= 16'd0;
			fail_count <= 0;
			edge_res_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MIN_SPEED: lim_min <= cfg_data;
					CFG_MAX_SPEED: lim_max <= cfg_data;
					CFG_TOLERANCE: lim_tol <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				fp = '{from_x, from_y, from_z, from_tgo};
				tp = '{to_x, to_y, to_z, to_time};
				edge_res_q = {edge_res_q, edge_predict(fp, tp)};
			end
			if (out_valid && !out_stall) begin
				if (edge_res_q.size() == 0) begin
					report("unexpected result", 36'd0, 36'd0);
				end else begin
					want = edge_res_q.pop_front();
					if (edge_valid !== want.ok)
						report("edge_valid", 36'(edge_valid), 36'(want.ok));
					if (edge_duration !== want.duration)
						report("edge_duration", 36'(edge_duration), 36'(want.duration));
					if (edge_distance !== want.distance)
						report("edge_distance", edge_distance, want.distance);
					if (edge_cost !== want.cost)
						report("edge_cost", edge_cost, want.cost);
				end
			end
		end
	end

endmodule

>>> bench/tb_spacetime_edge_feasibility_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spacetime_edge_feasibility_unit
// Drives edge transactions and register writes into the feasibility unit over
// several limit settings and idling patterns; the monitor does the checking.
// ----------------------------------------------------------------------------
module tb_spacetime_edge_feasibility_unit;
	import stef_pkg::*;

	// index 3 decodes to nothing, the write must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 100;   // pipeline is 76 deep

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [31:0]   from_x, from_y, from_z, from_tgo;
	logic signed [31:0]   to_x, to_y, to_z, to_time;
	logic                 out_valid;
	logic                 out_stall;
	logic                 edge_valid;
	logic [32:0]          edge_duration;
	logic [35:0]          edge_distance;
	logic [35:0]          edge_cost;
	int                   fail_count;
	int                   pending;

	int idle_pct;    // sender gap chance, percent
	int stall_pct;   // receiver stall chance, percent

	spacetime_edge_feasibility_unit dut (.*);
	edge_check_monitor mon (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver side: stall drawn fresh every cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	// One edge transaction; holds until taken, then maybe idles a while.
	task automatic send_edge(input logic [31:0] fx, fy, fz, ft, tx, ty, tz, tt);
		in_valid  <= 1'b1;
		from_x    <= fx;
		from_y    <= fy;
		from_z    <= fz;
		from_tgo  <= ft;
		to_x      <= tx;
		to_y      <= ty;
		to_z      <= tz;
		to_time   <= tt;
		do @(posedge clk); while (in_stall);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Waits out the pipeline, then writes one register.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(input logic [31:0] mn, mx, input logic [15:0] tol);
		write_reg(CFG_MIN_SPEED, mn);
		write_reg(CFG_MAX_SPEED, mx);
		write_reg(CFG_TOLERANCE, {16'd0, tol});
	endtask

	// Random edge: mostly a feasible-looking shape, sometimes raw noise.
	task automatic random_edge();
		logic [31:0] base [4];
		logic [31:0] gap;
		logic [31:0] span;
		for (int i = 0; i < 4; i++)
			base[i] = $urandom_range(99) < 50 ? $urandom() : 32'($signed($urandom()) >>> 2);
		if ($urandom_range(99) < 25) begin
			send_edge($urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom());
		end else begin
			gap  = $urandom_range(99) < 80 ? $urandom_range(1 << 20) : $urandom_range(1 << 29);
			span = gap >> $urandom_range(0, 3);
			send_edge(base[0], base[1], base[2], base[3] + gap,
				base[0] + $signed($urandom_range(2 * span)) - $signed(span),
				base[1] + $signed($urandom_range(span)) - $signed(span / 2),
				base[2] + $signed($urandom_range(span / 2 + 1)) - $signed(span / 4),
				base[3]);
		end
	endtask

	initial begin
		int idle_set[4]  = '{0, 59, 0, 30};
		int stall_set[4] = '{0, 0, 59, 30};
		int guard;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MIN_SPEED;
		cfg_data  = '0;
		in_valid  = 1'b0;
		{from_x, from_y, from_z, from_tgo} = '0;
		{to_x, to_y, to_z, to_time}        = '0;
		idle_pct  = 0;
		stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed edges under reset limits (speed 0..1, no slack).
		send_edge(0, 0, 0, 0, 0, 0, 0, 0);                          // zero gap
		send_edge(0, 0, 0, 1, 0, 0, 0, 0);                          // smallest gap
		send_edge(0, 0, 0, 32'h10000, 32'h10000, 0, 0, 0);          // speed exactly max
		send_edge(0, 0, 0, 32'h10000, 32'h10001, 0, 0, 0);          // just over max
		send_edge(5, 7, 9, 32'h7fffffff, 5, 7, 9, 32'h80000000);    // widest gap, still
		send_edge(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
		send_edge(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff); // negative gap
		send_edge(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			0, 0, 0, 32'hffffffff);
		send_edge(0, 0, 0, 32'h30000, 32'h10000, 32'h10000, 32'h10000, 0);

		// Slack on the gap: gap equal to tolerance, then one above.
		write_reg(CFG_UNUSED, 32'hdeadbeef);
		set_limits(32'd0, 32'h10000, 16'h0100);
		send_edge(0, 0, 0, 32'h100, 0, 0, 0, 0);
		send_edge(0, 0, 0, 32'h101, 0, 0, 0, 0);
		send_edge(0, 0, 0, 32'h10000, 32'h10100, 0, 0, 0);          // over max, within slack
		send_edge(0, 0, 0, 32'h10000, 32'h10101, 0, 0, 0);
		// Tolerance above min_speed: lower bound drops out.
		set_limits(32'h0080, 32'h10000, 16'h0100);
		send_edge(0, 0, 0, 32'h10000, 0, 0, 0, 0);
		// Positive lower bound: a stationary edge is too slow.
		set_limits(32'h8000, 32'h20000, 16'h0000);
		send_edge(0, 0, 0, 32'h10000, 0, 0, 0, 0);
		send_edge(0, 0, 0, 32'h10000, 32'h8000, 0, 0, 0);           // exactly min
		send_edge(0, 0, 0, 32'h10000, 32'h7fff, 0, 0, 0);
		// Top of every register.
		set_limits(32'hffffffff, 32'hffffffff, 16'hffff);
		send_edge(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
		send_edge(0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h80000000);

		// Random phases over a spread of limit settings.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_limits(32'd0, 32'h10000, 16'd0);
				1: set_limits(32'h4000, 32'h18000, 16'h0800);
				2: set_limits(32'd0, 32'd0, 16'd0);
				3: set_limits(32'h0100, 32'h10000, 16'h8000);
				4: set_limits(32'hffffffff, 32'hffffffff, 16'hffff);
				5: set_limits($urandom(), $urandom(), 16'($urandom()));
				6: set_limits(32'h2000, 32'h30000, 16'hffff);
				default: set_limits(32'h8000, 32'h12000, 16'h0010);
			endcase
			idle_pct  = idle_set[ph % 4];
			stall_pct = stall_set[ph % 4];
			for (int n = 0; n < 180; n++) begin
				random_edge();
				if (n == 90 && ph == 1) begin
					// sender holds off until the pipeline has fully drained
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
		end
		in_valid  <= 1'b0;
		stall_pct = 30;

		guard = 0;
		while (pending != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
